/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Clocked on clk, disabled while arst_n is low; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, cond, prop, msg)
`endif
`endif

/* rtl/cksm_pkg.sv */
// Types, sizes and shift helpers for the canonical k-mer subsequence matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cksm_pkg;
	localparam int KMER_BASES = 32;
	localparam int TRIM_BASES = 4;
	localparam int KMER_W = 64;
	localparam int TEXT_W = 2 * KMER_BASES;
	// trimmed pattern length, may be zero or negative
	localparam int PLEN = KMER_BASES - 2 * TRIM_BASES;
	localparam int PLEN_EFF = (PLEN > 0) ? PLEN : 1;
	localparam int PTR_W = $clog2(PLEN_EFF + 1);
	localparam int IDX_W = (PLEN_EFF > 1) ? $clog2(PLEN_EFF) : 1;
	// text bases consumed per pipeline stage
	localparam int BPS = 4;
	localparam int STAGES = (KMER_BASES + BPS - 1) / BPS;
	localparam int LATENCY = STAGES + 1;
	localparam logic [1:0] COMP_MASK = 2'b10;

	typedef struct packed {
		logic [KMER_W-1:0] pattern_kmer;
		logic [KMER_W-1:0] text_kmer;
	} kmer_pair_t;

	typedef struct packed {
		logic forward_found;
		logic reverse_found;
		logic match;
	} match_result_t;

	typedef struct packed {
		logic [KMER_W-1:0]     pattern;
		logic [TEXT_W-1:0]     window;   // unscanned text bases, next one on top
		logic [KMER_BASES-1:0] live;     // marks real text bases in window
		logic [PTR_W-1:0]      p_fwd;
		logic [PTR_W-1:0]      p_rev;
	} scan_state_t;

	// bit offset of trimmed forward base i
	function automatic int fwd_shift(input int i);
		int sh;
		sh = 2 * (KMER_BASES - 1 - TRIM_BASES - i);
		return (sh < 0) ? 0 : sh;
	endfunction

	// bit offset of the source base of trimmed reverse-complement base i
	function automatic int rc_shift(input int i);
		int sh;
		sh = 2 * (TRIM_BASES + i);
		return (sh > KMER_W - 2) ? 0 : sh;
	endfunction
endpackage

/* rtl/cksm_scan_step.sv */
// One pipeline step of the greedy subsequence scan: consumes BPS text bases
// for the forward and reverse-complement lanes. Depends on cksm_pkg.
`timescale 1ns / 1ps
module cksm_scan_step import cksm_pkg::*; (
	input  scan_state_t cur,
	output scan_state_t nxt
);
	logic [1:0] fwd_b [PLEN_EFF];
	logic [1:0] rc_b [PLEN_EFF];

	always_comb begin
		for (int i = 0; i < PLEN_EFF; i++) begin
			fwd_b[i] = 2'(cur.pattern >> fwd_shift(i));
			rc_b[i] = 2'(cur.pattern >> rc_shift(i)) ^ COMP_MASK;
		end
	end

	always_comb begin
		logic [PTR_W-1:0] pf;
		logic [PTR_W-1:0] pr;
		logic [1:0] tb;
		logic [TEXT_W-1:0] win;
		logic [KMER_BASES-1:0] lv;
		pf = cur.p_fwd;
		pr = cur.p_rev;
		win = cur.window;
		lv = cur.live;
		for (int k = 0; k < BPS; k++) begin
			tb = win[TEXT_W-1 -: 2];
			// greedy: a matching live text base advances the pattern pointer until it reaches the trimmed length
			if (lv[KMER_BASES-1]) begin
				if (PLEN > 0 && pf < PTR_W'(PLEN_EFF) && tb == fwd_b[pf[IDX_W-1:0]]) begin
					pf = pf + PTR_W'(1);
				end
				if (PLEN > 0 && pr < PTR_W'(PLEN_EFF) && tb == rc_b[pr[IDX_W-1:0]]) begin
					pr = pr + PTR_W'(1);
				end
			end
			win = win << 2;
			lv = lv << 1;
		end
		nxt.pattern = cur.pattern;
		nxt.window = win;
		nxt.live = lv;
		nxt.p_fwd = pf;
		nxt.p_rev = pr;
	end
endmodule

/* rtl/canonical_kmer_subsequence_matcher.sv */
// start is carried to the done strobe through the valid_s stage bits and then done_q.
// Throughput: one item per cycle; each of the STAGES scan stages takes BPS
// text bases for both lanes, and a final register forms the flags.
// busy is always low: no state between items and the receiver cannot stall.
// Reset clears the stage valid bits and the done strobe; payload is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module canonical_kmer_subsequence_matcher import cksm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kmer_pair_t    kmers,
	output logic          busy,
	output logic          done,
	output match_result_t result
);
	scan_state_t head;
	scan_state_t step_out [STAGES];
	scan_state_t pipe_s [STAGES];
	logic [STAGES-1:0] valid_s;
	logic done_q;
	match_result_t result_q;
	logic fwd_hit;
	logic rev_hit;

	assign busy = 1'b0;

	always_comb begin
		head.pattern = kmers.pattern_kmer;
		head.window = kmers.text_kmer[TEXT_W-1:0];
		head.live = '1;
		head.p_fwd = '0;
		head.p_rev = '0;
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			cksm_scan_step u_step (.cur(head), .nxt(step_out[g]));
		end else begin : g_rest
			cksm_scan_step u_step (.cur(pipe_s[g-1]), .nxt(step_out[g]));
		end

		always_ff @(posedge clk) begin
			pipe_s[g] <= step_out[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
			done_q <= 1'b0;
		end else begin
			valid_s <= {valid_s[STAGES-2:0], start};
			done_q <= valid_s[STAGES-1];
		end
	end

	// empty trimmed pattern counts as found
	assign fwd_hit = (PLEN <= 0) || (pipe_s[STAGES-1].p_fwd == PTR_W'(PLEN_EFF));
	assign rev_hit = (PLEN <= 0) || (pipe_s[STAGES-1].p_rev == PTR_W'(PLEN_EFF));

	always_ff @(posedge clk) begin
		result_q.forward_found <= fwd_hit;
		result_q.reverse_found <= rev_hit;
		result_q.match <= fwd_hit | rev_hit;
	end

	assign done = done_q;
	assign result = result_q;

	`ASSERT_IMPLIES(a_done_follows_start, done, $past(start, LATENCY),
		"done without an item accepted LATENCY cycles earlier")
	`ASSERT_IMPLIES(a_match_is_or, done,
		result.match == (result.forward_found || result.reverse_found),
		"match flag disagrees with lane flags")
	`ASSERT_IMPLIES(a_ptr_bound, valid_s[STAGES-1],
		pipe_s[STAGES-1].p_fwd <= PTR_W'(PLEN_EFF) && pipe_s[STAGES-1].p_rev <= PTR_W'(PLEN_EFF),
		"pattern pointer ran past trimmed length")
	`ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
endmodule
